FILE: src/salc_pkg.sv
// Shared constants and configuration type for the set-associative LRU tag store.
package salc_pkg;

    // Access kinds.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    // Prefetch modes.
    localparam logic [1:0] PF_OFF    = 2'd0;
    localparam logic [1:0] PF_ALWAYS = 2'd1;
    localparam logic [1:0] PF_MISS   = 2'd2;

    // Configuration register indexes and port widths.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOCATE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFETCH  = 2'd2;

    // Width of the running hit count.
    localparam int HIT_W = 32;

    typedef struct packed {
        logic [2:0] ways_log2;
        logic       allocate_on_store;
        logic [1:0] prefetch_mode;
    } t_cfg;

endpackage

FILE: src/salc_fifo.sv
// Two-entry queue that carries classified accesses from the front end to the back end.
module salc_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_rd,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             wr_ok;
    logic             rd_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_ok) begin
                r_wp <= ~r_wp;
            end
            if (rd_ok) begin
                r_rp <= ~r_rp;
            end
            if (wr_ok && !rd_ok) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (rd_ok && !wr_ok) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: src/salc_front.sv
// Front end: takes accesses, works out set rows, lane offsets and tags, and queues them.
module salc_front #(
    parameter int TOTAL_LINES  = 512,
    parameter int BLOCK_BYTES  = 32,
    parameter int MAX_WAYS     = 16,
    parameter int ADDRESS_BITS = 32,
    parameter int JW           = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic                    i_op,
    input  logic [ADDRESS_BITS-1:0] i_address,
    input  salc_pkg::t_cfg          i_cfg,
    input  logic [2:0]              i_lw,
    input  logic                    i_job_take,
    output logic                    o_job_empty,
    output logic [JW-1:0]           o_job
);

    localparam int LANES     = (MAX_WAYS < TOTAL_LINES) ? MAX_WAYS : TOTAL_LINES;
    localparam int LW_MAX    = $clog2(LANES);
    localparam int LIW       = (LW_MAX > 0) ? LW_MAX : 1;
    localparam int ROWS      = TOTAL_LINES / LANES;
    localparam int RAW       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LOG_LINES = $clog2(TOTAL_LINES);
    localparam int OBITS     = $clog2(BLOCK_BYTES);
    localparam int TW        = ADDRESS_BITS - OBITS - LOG_LINES + LW_MAX;

    typedef struct packed {
        logic           fill;
        logic           pf_en;
        logic           pf_miss;
        logic [RAW-1:0] d_row;
        logic [LIW-1:0] d_off;
        logic [TW-1:0]  d_tag;
        logic [RAW-1:0] p_row;
        logic [LIW-1:0] p_off;
        logic [TW-1:0]  p_tag;
    } t_job;

    t_job                    job;
    logic [ADDRESS_BITS-1:0] next_addr;
    logic [LOG_LINES-1:0]    d_blk;
    logic [LOG_LINES-1:0]    p_blk;
    logic [LOG_LINES-1:0]    d_line;
    logic [LOG_LINES-1:0]    p_line;
    int                      tag_shift;

    // Set placement: the first line of the set is the block's set number scaled by the ways.
    always_comb begin
        next_addr = i_address + ADDRESS_BITS'(BLOCK_BYTES);
        tag_shift = OBITS + LOG_LINES - int'(i_lw);
        d_blk     = LOG_LINES'(i_address >> OBITS);
        p_blk     = LOG_LINES'(next_addr >> OBITS);
        d_line    = d_blk << i_lw;
        p_line    = p_blk << i_lw;

        job.d_row = RAW'(d_line >> LW_MAX);
        job.d_off = LIW'(d_line);
        job.d_tag = TW'(i_address >> tag_shift);
        job.p_row = RAW'(p_line >> LW_MAX);
        job.p_off = LIW'(p_line);
        job.p_tag = TW'(next_addr >> tag_shift);

        job.fill    = !(i_op == salc_pkg::OP_STORE && !i_cfg.allocate_on_store);
        job.pf_en   = (i_cfg.prefetch_mode == salc_pkg::PF_ALWAYS)
                   || (i_cfg.prefetch_mode == salc_pkg::PF_MISS);
        job.pf_miss = (i_cfg.prefetch_mode == salc_pkg::PF_MISS);
    end

    // Queue towards the back end; its full flag is the input full flag.
    salc_fifo #(
        .WIDTH ($bits(t_job))
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_data  (job),
        .o_full  (full),
        .i_rd    (i_job_take),
        .o_empty (o_job_empty),
        .o_data  (o_job)
    );

endmodule

FILE: src/salc_back.sv
// Back end: read-modify-write of one set row per lookup, LRU update, hit count and result slot.
module salc_back #(
    parameter int TOTAL_LINES  = 512,
    parameter int BLOCK_BYTES  = 32,
    parameter int MAX_WAYS     = 16,
    parameter int ADDRESS_BITS = 32,
    parameter int JW           = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_inval,
    input  logic [2:0]                 i_lw,
    input  logic                       i_job_empty,
    input  logic [JW-1:0]              i_job,
    output logic                       o_job_take,
    output logic                       empty,
    input  logic                       pop,
    output logic                       o_hit,
    output logic                       o_prefetch_done,
    output logic                       o_prefetch_present,
    output logic [salc_pkg::HIT_W-1:0] o_hit_total
);

    localparam int LANES     = (MAX_WAYS < TOTAL_LINES) ? MAX_WAYS : TOTAL_LINES;
    localparam int LW_MAX    = $clog2(LANES);
    localparam int LIW       = (LW_MAX > 0) ? LW_MAX : 1;
    localparam int ROWS      = TOTAL_LINES / LANES;
    localparam int RAW       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LOG_LINES = $clog2(TOTAL_LINES);
    localparam int OBITS     = $clog2(BLOCK_BYTES);
    localparam int TW        = ADDRESS_BITS - OBITS - LOG_LINES + LW_MAX;
    localparam int RKW       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam logic [RKW-1:0] SAT = RKW'(MAX_WAYS - 1);
    localparam logic [salc_pkg::HIT_W-1:0] HIT_MAX = '1;

    typedef struct packed {
        logic           fill;
        logic           pf_en;
        logic           pf_miss;
        logic [RAW-1:0] d_row;
        logic [LIW-1:0] d_off;
        logic [TW-1:0]  d_tag;
        logic [RAW-1:0] p_row;
        logic [LIW-1:0] p_off;
        logic [TW-1:0]  p_tag;
    } t_job;

    typedef struct packed {
        logic [LANES-1:0][TW-1:0]  tag;
        logic [LANES-1:0]          vld;
        logic [LANES-1:0][RKW-1:0] rank;
    } t_row;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEM,
        S_PRD,
        S_PEV
    } t_state;

    t_state                     r_state;
    t_job                       r_job;
    t_job                       head;
    logic                       r_out_valid;
    logic                       r_hit;
    logic                       r_pf_done;
    logic                       r_pf_present;
    logic [salc_pkg::HIT_W-1:0] r_hit_cnt;

    t_row                       r_rows [ROWS];
    logic [ROWS-1:0]            r_row_vld;
    t_row                       r_rd_row;
    logic                       r_rd_rv;
    logic [RAW-1:0]             rd_addr;
    logic [RAW-1:0]             wr_addr;
    logic                       wr_en;
    logic                       start;

    // Lookup inputs and outputs.
    logic [LIW-1:0]             ev_off;
    logic [TW-1:0]              ev_tag;
    logic                       ev_fill;
    logic                       ev_hit;
    t_row                       n_row;
    logic [LANES-1:0]           act;
    logic [LANES-1:0]           e_v;
    logic [LANES-1:0][RKW-1:0]  e_rk;
    logic [LANES-1:0]           match;
    logic [LANES-1:0]           inv;
    logic [LANES-1:0]           first_inv;
    logic [LANES-1:0]           vic;
    logic [LANES-1:0]           sel;
    logic [RKW-1:0]             sel_rk;
    logic                       pf_go;

    assign head       = i_job;
    assign start      = (r_state == S_IDLE) && !i_job_empty && (!r_out_valid || pop);
    assign o_job_take = start;

    assign empty              = !r_out_valid;
    assign o_hit              = r_hit;
    assign o_prefetch_done    = r_pf_done;
    assign o_prefetch_present = r_pf_present;
    assign o_hit_total        = r_hit_cnt;

    // Row read address: the queue head while idle, the prefetch row otherwise.
    assign rd_addr = (r_state == S_IDLE) ? head.d_row : r_job.p_row;
    assign wr_addr = (r_state == S_DEM) ? r_job.d_row : r_job.p_row;
    assign wr_en   = (r_state == S_DEM) || (r_state == S_PEV);

    // The lookup in the demand state uses the demand fields, otherwise the prefetch fields.
    always_comb begin
        if (r_state == S_DEM) begin
            ev_off  = r_job.d_off;
            ev_tag  = r_job.d_tag;
            ev_fill = r_job.fill;
        end else begin
            ev_off  = r_job.p_off;
            ev_tag  = r_job.p_tag;
            ev_fill = 1'b1;
        end
    end

    // Set lookup and LRU update over the lanes of one row.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            e_v[l]   = r_rd_rv && r_rd_row.vld[l];
            e_rk[l]  = r_rd_rv ? r_rd_row.rank[l] : '0;
            act[l]   = ((LIW'(l) >> i_lw) == (ev_off >> i_lw));
            match[l] = act[l] && e_v[l] && (r_rd_row.tag[l] == ev_tag);
            inv[l]   = act[l] && !e_v[l];
        end
        first_inv = inv & (~inv + 1'b1);

        // Victim is the oldest way, the lowest one where ages tie.
        for (int l = 0; l < LANES; l++) begin
            vic[l] = act[l];
            for (int k = 0; k < LANES; k++) begin
                if (act[k] && k != l) begin
                    if (k < l) begin
                        vic[l] = vic[l] && (e_rk[l] > e_rk[k]);
                    end else begin
                        vic[l] = vic[l] && (e_rk[l] >= e_rk[k]);
                    end
                end
            end
        end

        ev_hit = |match;
        sel    = ev_hit ? match : vic;
        sel_rk = '0;
        for (int l = 0; l < LANES; l++) begin
            if (sel[l]) begin
                sel_rk = sel_rk | e_rk[l];
            end
        end

        n_row.tag  = r_rd_row.tag;
        n_row.vld  = e_v;
        n_row.rank = e_rk;
        if (ev_hit || (ev_fill && !(|inv))) begin
            // Hit, or replacement of the oldest way: younger lines age by one.
            for (int l = 0; l < LANES; l++) begin
                if (sel[l]) begin
                    n_row.rank[l] = '0;
                    if (!ev_hit) begin
                        n_row.tag[l] = ev_tag;
                    end
                end else if (act[l] && e_v[l] && e_rk[l] < sel_rk && e_rk[l] < SAT) begin
                    n_row.rank[l] = e_rk[l] + 1'b1;
                end
            end
        end else if (ev_fill) begin
            // Fill into the lowest empty way: every valid line ages by one.
            for (int l = 0; l < LANES; l++) begin
                if (first_inv[l]) begin
                    n_row.vld[l]  = 1'b1;
                    n_row.tag[l]  = ev_tag;
                    n_row.rank[l] = '0;
                end else if (act[l] && e_v[l] && e_rk[l] < SAT) begin
                    n_row.rank[l] = e_rk[l] + 1'b1;
                end
            end
        end
    end

    assign pf_go = r_job.pf_en && !(r_job.pf_miss && ev_hit);

    // Tag store rows: one registered read and one write per cycle.
    always_ff @(posedge i_clk) begin
        r_rd_row <= r_rows[rd_addr];
        if (wr_en) begin
            r_rows[wr_addr] <= n_row;
        end
    end

    // Row valid flags: a row never written reads as empty with all ages zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_inval) begin
            r_row_vld <= '0;
            r_rd_rv   <= 1'b0;
        end else begin
            r_rd_rv <= r_row_vld[rd_addr];
            if (wr_en) begin
                r_row_vld[wr_addr] <= 1'b1;
            end
        end
    end

    // Sequencer, hit count and result slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_hit_cnt    <= '0;
            r_hit        <= 1'b0;
            r_pf_done    <= 1'b0;
            r_pf_present <= 1'b0;
        end else begin
            if (pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_job   <= head;
                        r_state <= S_DEM;
                    end
                end
                S_DEM: begin
                    r_hit <= ev_hit;
                    if (ev_hit && r_hit_cnt != HIT_MAX) begin
                        r_hit_cnt <= r_hit_cnt + 1'b1;
                    end
                    if (pf_go) begin
                        r_state <= S_PRD;
                    end else begin
                        r_pf_done    <= 1'b0;
                        r_pf_present <= 1'b0;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                S_PRD: begin
                    r_state <= S_PEV;
                end
                S_PEV: begin
                    r_pf_done    <= 1'b1;
                    r_pf_present <= ev_hit;
                    r_out_valid  <= 1'b1;
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: src/set_assoc_lru_cache_hit_tracker.sv
// Top level of the set-associative LRU tag store with hit count and next-line prefetch.
// Each access is a lookup in one set of the TOTAL_LINES-line store; a tag store row holds all
// ways of a set, so a lookup is one row read then one row write. An access runs S_IDLE and
// S_DEM, then S_PRD and S_PEV if a next-line prefetch follows, set by the single
// row port of the tag store. A two-entry queue lets new accesses be transferred while a lookup
// or an unread result is pending. Results come out in order, one per access, with the running
// hit count after that access. Writing ways_log2 empties the whole store at once.
module set_assoc_lru_cache_hit_tracker #(
    parameter int TOTAL_LINES  = 512,
    parameter int BLOCK_BYTES  = 32,
    parameter int MAX_WAYS     = 16,
    parameter int ADDRESS_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            i_op,
    input  logic [ADDRESS_BITS-1:0]         i_address,
    output logic                            empty,
    input  logic                            pop,
    output logic                            o_hit,
    output logic                            o_prefetch_done,
    output logic                            o_prefetch_present,
    output logic [salc_pkg::HIT_W-1:0]      o_hit_total,
    input  logic                            i_cfg_we,
    input  logic [salc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LANES     = (MAX_WAYS < TOTAL_LINES) ? MAX_WAYS : TOTAL_LINES;
    localparam int LW_MAX    = $clog2(LANES);
    localparam int LIW       = (LW_MAX > 0) ? LW_MAX : 1;
    localparam int ROWS      = TOTAL_LINES / LANES;
    localparam int RAW       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int TW        = ADDRESS_BITS - $clog2(BLOCK_BYTES) - $clog2(TOTAL_LINES) + LW_MAX;
    localparam int JW        = 2 * (RAW + LIW + TW) + 3;

    salc_pkg::t_cfg r_cfg;
    logic           r_inval;
    logic [2:0]     lw;
    logic           job_empty;
    logic           job_take;
    logic [JW-1:0]  job;

    // Configuration registers; a write to ways_log2 also empties the store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ways_log2         <= 3'd1;
            r_cfg.allocate_on_store <= 1'b1;
            r_cfg.prefetch_mode     <= salc_pkg::PF_OFF;
            r_inval                 <= 1'b0;
        end else begin
            r_inval <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    salc_pkg::CFG_WAYS_LOG2: begin
                        r_cfg.ways_log2 <= i_cfg_data;
                        r_inval         <= 1'b1;
                    end
                    salc_pkg::CFG_ALLOCATE: begin
                        r_cfg.allocate_on_store <= i_cfg_data[0];
                    end
                    salc_pkg::CFG_PREFETCH: begin
                        r_cfg.prefetch_mode <= i_cfg_data[1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Associativity above what a row holds is taken as the largest supported.
    assign lw = (int'(r_cfg.ways_log2) > LW_MAX) ? 3'(LW_MAX) : r_cfg.ways_log2;

    salc_front #(
        .TOTAL_LINES  (TOTAL_LINES),
        .BLOCK_BYTES  (BLOCK_BYTES),
        .MAX_WAYS     (MAX_WAYS),
        .ADDRESS_BITS (ADDRESS_BITS),
        .JW           (JW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_op        (i_op),
        .i_address   (i_address),
        .i_cfg       (r_cfg),
        .i_lw        (lw),
        .i_job_take  (job_take),
        .o_job_empty (job_empty),
        .o_job       (job)
    );

    salc_back #(
        .TOTAL_LINES  (TOTAL_LINES),
        .BLOCK_BYTES  (BLOCK_BYTES),
        .MAX_WAYS     (MAX_WAYS),
        .ADDRESS_BITS (ADDRESS_BITS),
        .JW           (JW)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_inval            (r_inval),
        .i_lw               (lw),
        .i_job_empty        (job_empty),
        .i_job              (job),
        .o_job_take         (job_take),
        .empty              (empty),
        .pop                (pop),
        .o_hit              (o_hit),
        .o_prefetch_done    (o_prefetch_done),
        .o_prefetch_present (o_prefetch_present),
        .o_hit_total        (o_hit_total)
    );

endmodule
